[rtl/core/otl_pkg.sv]
// ----------------------------------------------------------------------------
// otl_pkg
// Shared types, constants and register codes of the overcurrent throttle
// limiter.
// ----------------------------------------------------------------------------
package otl_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CUR_W  = 17;
    localparam int CEIL_W = 19;
    localparam int MV_W   = 16;
    localparam int GAIN_W = 8;
    localparam int STEP_W = 16;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 19;
    localparam int PROD_W = GAIN_W + CUR_W;

    localparam int SCALE_W     = 13;
    localparam int SCALE_SHIFT = 8;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 13'd4495;
    localparam logic [CUR_W-1:0]   CUR_MAX   = 17'd131071;

    localparam logic [CEIL_W-1:0] CEIL_RESET = 19'd294912;

    localparam logic [CUR_W-1:0]  RST_CUR_THR  = 17'd11264;
    localparam logic [GAIN_W-1:0] RST_GAIN     = 8'd15;
    localparam logic [STEP_W-1:0] RST_STEP     = 16'd2560;
    localparam logic [CEIL_W-1:0] RST_CEIL_MAX = 19'd294912;
    localparam logic [CEIL_W-1:0] RST_CEIL_MIN = 19'd25600;
    localparam logic [CEIL_W-1:0] RST_OC_LEVEL = 19'd243200;
    localparam logic [MV_W-1:0]   RST_LOW_MV   = 16'd14000;

    localparam logic [IDX_W-1:0] REG_CUR_THR  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CEIL_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_CEIL_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_OC_LEVEL = 3'd5;
    localparam logic [IDX_W-1:0] REG_LOW_MV   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW_V  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OC     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISARM = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CUR_W-1:0]  cur_thr;
        logic [GAIN_W-1:0] gain;
        logic [STEP_W-1:0] step;
        logic [CEIL_W-1:0] ceil_max;
        logic [CEIL_W-1:0] ceil_min;
        logic [CEIL_W-1:0] oc_level;
        logic [MV_W-1:0]   low_mv;
    } t_cfg;

    typedef struct packed {
        logic [CUR_W-1:0] cur;
        logic             over;
        logic [CUR_W-1:0] excess;
        logic [MV_W-1:0]  battery_mv;
        logic             disarm;
    } t_item;

endpackage

[rtl/core/otl_if.sv]
// ----------------------------------------------------------------------------
// otl_if
// Sample, result and register-write channels of the throttle limiter.
// ----------------------------------------------------------------------------
interface otl_in_if
    import otl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_current;
    logic [MV_W-1:0]        battery_mv;
    logic                   disarm_pending;

    modport source (output valid, raw_current, battery_mv, disarm_pending, input ready);
    modport sink   (input valid, raw_current, battery_mv, disarm_pending, output ready);
endinterface

interface otl_out_if
    import otl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CUR_W-1:0]  measured_current;
    logic [CEIL_W-1:0] throttle_ceiling;
    logic [MODE_W-1:0] alarm_mode;

    modport source (output valid, measured_current, throttle_ceiling, alarm_mode,
                    input ready);
    modport sink   (input valid, measured_current, throttle_ceiling, alarm_mode,
                    output ready);
endinterface

interface otl_cfg_if
    import otl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/otl_front.sv]
// ----------------------------------------------------------------------------
// otl_front
// Accept a sample, scale it to 1/256 A and classify it against the current
// threshold before handing it to the queue.
// ----------------------------------------------------------------------------
module otl_front
    import otl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_raw_current,
    input  logic [MV_W-1:0]        i_battery_mv,
    input  logic                   i_disarm_pending,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_item                  o_item
);
    localparam int PW = SAMPLE_BITS + SCALE_W;
    localparam int SW = PW - SCALE_SHIFT;
    localparam int AW = (SW > CUR_W) ? SW : CUR_W;

    logic [PW-1:0]    prod;
    logic [AW-1:0]    scaled;
    logic [CUR_W-1:0] cur;
    logic             accept;

    logic             r_valid;
    logic [CUR_W-1:0] r_cur;
    logic [MV_W-1:0]  r_mv;
    logic             r_disarm;

    assign prod   = PW'(i_raw_current) * PW'(SCALE_NUM);
    assign scaled = AW'(prod >> SCALE_SHIFT);
    assign cur    = (scaled > AW'(CUR_MAX)) ? CUR_MAX : scaled[CUR_W-1:0];

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur    <= cur;
            r_mv     <= i_battery_mv;
            r_disarm <= i_disarm_pending;
        end
    end

    always_comb begin
        o_item.cur        = r_cur;
        o_item.over       = r_cur > i_cfg.cur_thr;
        o_item.excess     = r_cur - i_cfg.cur_thr;
        o_item.battery_mv = r_mv;
        o_item.disarm     = r_disarm;
    end

endmodule

[rtl/core/otl_queue.sv]
// ----------------------------------------------------------------------------
// otl_queue
// Short queue of classified samples between the front and back parts.
// ----------------------------------------------------------------------------
module otl_queue
    import otl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("otl_queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("otl_queue: pop while empty");

    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> r_count == $past(r_count) - 1'b1)
        else $error("otl_queue: count did not drop on pop");

endmodule

[rtl/core/otl_back.sv]
// ----------------------------------------------------------------------------
// otl_back
// Update the throttle ceiling from a classified sample, clamp it, pick the
// alarm mode and hold the result for the consumer.
// ----------------------------------------------------------------------------
module otl_back
    import otl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_empty,
    input  t_item i_item,
    output logic o_pop,
    otl_out_if.source o_out
);
    localparam int NW = PROD_W + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_item             r_item;
    logic [PROD_W-1:0] r_prod;
    logic [CEIL_W-1:0] r_ceil;
    logic [CEIL_W-1:0] n_ceil;
    logic              r_ovalid;
    logic [CUR_W-1:0]  r_ocur;
    logic [CEIL_W-1:0] r_oceil;
    logic [MODE_W-1:0] r_omode;
    logic [MODE_W-1:0] mode;
    logic              out_free;
    logic signed [NW-1:0] next;
    logic signed [NW-1:0] upper;

    assign out_free = !r_ovalid || o_out.ready;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        if (r_item.over) begin
            next = $signed({(NW - CEIL_W)'(0), r_ceil}) - $signed({2'b00, r_prod});
        end else begin
            next = $signed({(NW - CEIL_W)'(0), r_ceil})
                 + $signed({(NW - STEP_W)'(0), i_cfg.step});
        end
        upper = (next > $signed({(NW - CEIL_W)'(0), i_cfg.ceil_max}))
              ? $signed({(NW - CEIL_W)'(0), i_cfg.ceil_max}) : next;
        n_ceil = (upper < $signed({(NW - CEIL_W)'(0), i_cfg.ceil_min}))
               ? i_cfg.ceil_min : upper[CEIL_W-1:0];
    end

    always_comb begin
        priority if (r_item.battery_mv <= i_cfg.low_mv) begin
            mode = MODE_LOW_V;
        end else if (r_ceil < i_cfg.oc_level) begin
            mode = MODE_OC;
        end else if (r_item.disarm) begin
            mode = MODE_DISARM;
        end else begin
            mode = MODE_NORMAL;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_MUL;
            S_MUL:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ceil   <= CEIL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_ceil <= n_ceil;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(i_cfg.gain) * PROD_W'(r_item.excess);
        end
        if (r_state == S_OUT && out_free) begin
            r_ocur  <= r_item.cur;
            r_oceil <= r_ceil;
            r_omode <= mode;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.measured_current = r_ocur;
    assign o_out.throttle_ceiling = r_oceil;
    assign o_out.alarm_mode       = r_omode;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_free) |=> r_state == S_OUT)
        else $error("otl_back: result dropped while output busy");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_MUL)
        else $error("otl_back: pop did not start an update");

    a_ceil_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_IDLE) |-> $stable(r_ceil))
        else $error("otl_back: ceiling moved while idle");

endmodule

[rtl/core/overcurrent_throttle_limiter.sv]
// ----------------------------------------------------------------------------
// overcurrent_throttle_limiter
// Sequencing: the back-end sequencer takes one sample at a time through
// pop, multiply, clamp and output load, and holds in output load while the
// output is busy; the front and queue buffer further samples meanwhile.
// Reset: registers take their defaults, the ceiling returns to 294912 and
// the queue and output register empty.
// ----------------------------------------------------------------------------
module overcurrent_throttle_limiter
    import otl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    otl_in_if.sink     i_in,
    otl_out_if.source  o_out,
    otl_cfg_if.sink    i_cfg
);
    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    logic  [SAMPLE_BITS-1:0] raw;

    assign raw         = SAMPLE_BITS'(i_in.raw_current);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cur_thr  <= RST_CUR_THR;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.step     <= RST_STEP;
            r_cfg.ceil_max <= RST_CEIL_MAX;
            r_cfg.ceil_min <= RST_CEIL_MIN;
            r_cfg.oc_level <= RST_OC_LEVEL;
            r_cfg.low_mv   <= RST_LOW_MV;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CUR_THR:  r_cfg.cur_thr  <= i_cfg.data[CUR_W-1:0];
                REG_GAIN:     r_cfg.gain     <= i_cfg.data[GAIN_W-1:0];
                REG_STEP:     r_cfg.step     <= i_cfg.data[STEP_W-1:0];
                REG_CEIL_MAX: r_cfg.ceil_max <= i_cfg.data[CEIL_W-1:0];
                REG_CEIL_MIN: r_cfg.ceil_min <= i_cfg.data[CEIL_W-1:0];
                REG_OC_LEVEL: r_cfg.oc_level <= i_cfg.data[CEIL_W-1:0];
                REG_LOW_MV:   r_cfg.low_mv   <= i_cfg.data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    otl_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .o_ready          (i_in.ready),
        .i_raw_current    (raw),
        .i_battery_mv     (i_in.battery_mv),
        .i_disarm_pending (i_in.disarm_pending),
        .i_cfg            (r_cfg),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_item           (front_item)
    );

    otl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    otl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
